/* src/mvlv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvlv_pkg
// shared types and constants of the latest-version selector
// ----------------------------------------------------------------------------
package mvlv_pkg;

    // field widths of the stream items
    localparam int KEY_FIELD_BITS = 64;
    localparam int VER_FIELD_BITS = 64;
    localparam int REF_FIELD_BITS = 32;

    // configuration port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_IDX_BITS  = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_IDX_SNAPSHOT_TS = 1'b0;

    // result queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int PUSH_CNT_BITS   = 2;
    // room needed for the worst row, which closes two groups
    localparam logic [QUEUE_CNT_BITS-1:0] QUEUE_ROOM_LIMIT =
        QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

    // one result item
    typedef struct packed {
        logic [KEY_FIELD_BITS-1:0] out_key;
        logic [VER_FIELD_BITS-1:0] out_version;
        logic [REF_FIELD_BITS-1:0] out_row_ref;
        logic                      out_last;
    } res_t;

    // results produced by one accepted row, compacted from entry 0
    typedef struct packed {
        logic [PUSH_CNT_BITS-1:0] n;
        res_t                     e0;
        res_t                     e1;
    } push_t;

endpackage
`default_nettype wire

/* src/mvlv_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvlv stream interfaces
// row request channel and result request channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface mvlv_row_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_key;
    logic [63:0] row_version;
    logic        delete_mark;
    logic [31:0] row_ref;
    logic        end_of_stream;

    modport source (
        output valid, row_key, row_version, delete_mark, row_ref, end_of_stream,
        input  ready
    );
    modport sink (
        input  valid, row_key, row_version, delete_mark, row_ref, end_of_stream,
        output ready
    );
endinterface

interface mvlv_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_key;
    logic [63:0] out_version;
    logic [31:0] out_row_ref;
    logic        out_last;

    modport source (
        output valid, out_key, out_version, out_row_ref, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_key, out_version, out_row_ref, out_last,
        output ready
    );
endinterface
`default_nettype wire

/* src/mvlv_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvlv_front
// takes one row a cycle while the queue has room, tracks the open key group and
// its kept row, and hands the closed groups' survivors to the result queue
// ----------------------------------------------------------------------------
module mvlv_front #(
    parameter int KEY_BITS = 64,
    parameter int REF_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mvlv_row_if.sink                   row_in,
    input  wire logic [63:0]           snapshot_ts,
    input  wire logic                  room,
    output mvlv_pkg::push_t            push
);
    import mvlv_pkg::*;

    localparam int REF_KEEP = (REF_BITS < REF_FIELD_BITS) ? REF_BITS : REF_FIELD_BITS;

    // open group and kept row
    logic [KEY_BITS-1:0] group_key_reg,      group_key_next;
    logic                group_key_valid_reg, group_key_valid_next;
    logic                chosen_valid_reg,   chosen_valid_next;
    logic [63:0]         chosen_version_reg, chosen_version_next;
    logic                chosen_deleted_reg, chosen_deleted_next;
    logic [REF_KEEP-1:0] chosen_ref_reg,     chosen_ref_next;

    logic                accept;
    logic [KEY_BITS-1:0] row_key_w;
    logic [REF_KEEP-1:0] row_ref_w;
    logic                key_change;
    logic                close_emit;
    logic                cv_open;
    logic [63:0]         cver_open;
    logic                take_row;
    logic                new_valid;
    logic [63:0]         new_version;
    logic                new_deleted;
    logic [REF_KEEP-1:0] new_ref;
    logic                final_emit;
    res_t                res_close;
    res_t                res_final;

    assign accept       = row_in.valid && room;
    assign row_in.ready = room;
    assign row_key_w    = row_in.row_key[KEY_BITS-1:0];
    assign row_ref_w    = row_in.row_ref[REF_KEEP-1:0];

    // group close and visibility check
    always_comb
    begin
        key_change = group_key_valid_reg && (row_key_w != group_key_reg);
        close_emit = key_change && chosen_valid_reg && !chosen_deleted_reg;

        cv_open   = key_change ? 1'b0  : chosen_valid_reg;
        cver_open = key_change ? 64'd0 : chosen_version_reg;

        take_row = (row_in.row_version <= snapshot_ts) &&
                   (!cv_open || (row_in.row_version > cver_open));

        new_valid   = take_row || cv_open;
        new_version = take_row ? row_in.row_version : cver_open;
        new_deleted = take_row ? row_in.delete_mark
                               : (!key_change && chosen_deleted_reg);
        new_ref     = take_row ? row_ref_w
                               : (key_change ? '0 : chosen_ref_reg);

        final_emit = row_in.end_of_stream && new_valid && !new_deleted;
    end

    // result items
    always_comb
    begin
        res_close.out_key     = KEY_FIELD_BITS'(group_key_reg);
        res_close.out_version = chosen_version_reg;
        res_close.out_row_ref = REF_FIELD_BITS'(chosen_ref_reg);
        res_close.out_last    = row_in.end_of_stream && !final_emit;

        res_final.out_key     = KEY_FIELD_BITS'(row_key_w);
        res_final.out_version = new_version;
        res_final.out_row_ref = REF_FIELD_BITS'(new_ref);
        res_final.out_last    = 1'b1;
    end

    // compact the results into the push bundle
    always_comb
    begin
        push.e0 = close_emit ? res_close : res_final;
        push.e1 = res_final;
        if (!accept)
        begin
            push.n = '0;
        end
        else
        begin
            push.n = PUSH_CNT_BITS'({1'b0, close_emit} + {1'b0, final_emit});
        end
    end

    // next group state
    always_comb
    begin
        if (row_in.end_of_stream)
        begin
            group_key_next       = '0;
            group_key_valid_next = 1'b0;
            chosen_valid_next    = 1'b0;
            chosen_version_next  = '0;
            chosen_deleted_next  = 1'b0;
            chosen_ref_next      = '0;
        end
        else
        begin
            group_key_next       = row_key_w;
            group_key_valid_next = 1'b1;
            chosen_valid_next    = new_valid;
            chosen_version_next  = new_version;
            chosen_deleted_next  = new_deleted;
            chosen_ref_next      = new_ref;
        end
    end

    // group state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_key_reg       <= '0;
            group_key_valid_reg <= 1'b0;
            chosen_valid_reg    <= 1'b0;
            chosen_version_reg  <= '0;
            chosen_deleted_reg  <= 1'b0;
            chosen_ref_reg      <= '0;
        end
        else if (accept)
        begin
            group_key_reg       <= group_key_next;
            group_key_valid_reg <= group_key_valid_next;
            chosen_valid_reg    <= chosen_valid_next;
            chosen_version_reg  <= chosen_version_next;
            chosen_deleted_reg  <= chosen_deleted_next;
            chosen_ref_reg      <= chosen_ref_next;
        end
    end

    // two results only come from a final row that also changes key
    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (row_in.end_of_stream && key_change))
        else $error("two results pushed outside a closing final row");

    // with two results the last mark sits on the second only
    a_last_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.e1.out_last && !push.e0.out_last))
        else $error("last mark misplaced on a double push");

    // a final row leaves no open group behind
    a_closed_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_in.end_of_stream) |=> (!group_key_valid_reg && !chosen_valid_reg))
        else $error("group still open after end of stream");

endmodule
`default_nettype wire

/* src/mvlv_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvlv_queue
// short result queue: takes up to two results a cycle from the front and
// presents one a cycle while the result channel is ready, straight from its
// registers
module mvlv_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mvlv_pkg::push_t  push,
    output logic                  room,
    mvlv_res_if.source            res_out
);
    import mvlv_pkg::*;

    res_t                      q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg,  count_next;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_plus1;
    logic                      pop;
    res_t                      head;

    assign room         = (count_reg <= QUEUE_ROOM_LIMIT);
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_BITS'(1);
    assign head         = q_mem_reg[rd_ptr_reg];
    assign pop          = res_out.valid && res_out.ready;

    // result channel
    assign res_out.valid       = (count_reg != '0);
    assign res_out.out_key     = head.out_key;
    assign res_out.out_version = head.out_version;
    assign res_out.out_row_ref = head.out_row_ref;
    assign res_out.out_last    = head.out_last;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push.n);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + QUEUE_CNT_BITS'(push.n) - QUEUE_CNT_BITS'(pop);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.n != '0)
        begin
            q_mem_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.n == PUSH_CNT_BITS'(2))
        begin
            q_mem_reg[wr_ptr_plus1] <= push.e1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* src/mvcc_latest_version_select.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvcc_latest_version_select
// keeps, per run of equal keys, the newest row visible at the snapshot
// timestamp and emits it when the run closes, unless it is delete-marked
// ----------------------------------------------------------------------------
// a result is registered in the queue as the row closing its group is accepted
// throughput: one row a cycle; the front group tracker decides in that cycle
// a final row that closes two groups queues two results, drained one a cycle
// from a four-entry queue on ready; rows stall while more than two results wait
// reset: rst_n clears group state, queue and snapshot_ts; no clearing pass
// ----------------------------------------------------------------------------
module mvcc_latest_version_select #(
    parameter int KEY_BITS = 64,
    parameter int REF_BITS = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    mvlv_row_if.sink                                    row_in,
    mvlv_res_if.source                                  res_out,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [mvlv_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [mvlv_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic      [mvlv_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                        pready
);
    import mvlv_pkg::*;

    logic [63:0]             snapshot_ts_reg, snapshot_ts_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_write;
    logic                    room;
    push_t                   push;

    // configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1 -: REG_IDX_BITS];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        snapshot_ts_next = snapshot_ts_reg;
        if (cfg_write && (reg_idx == REG_IDX_SNAPSHOT_TS))
        begin
            snapshot_ts_next = pwdata;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IDX_SNAPSHOT_TS: prdata = snapshot_ts_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snapshot_ts_reg <= '0;
        end
        else
        begin
            snapshot_ts_reg <= snapshot_ts_next;
        end
    end

    // group tracker
    mvlv_front #(
        .KEY_BITS (KEY_BITS),
        .REF_BITS (REF_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_in      (row_in),
        .snapshot_ts (snapshot_ts_reg),
        .room        (room),
        .push        (push)
    );

    // result queue and output side
    mvlv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .res_out (res_out)
    );

endmodule
`default_nettype wire
